>>> rtl/dam_pkg.sv
// dam_pkg: shared types and codes for the deadband axis mapper.
// Holds the pipeline control struct and the register index codes.
// No dependencies.
package dam_pkg;

   // control that travels alongside each transaction through the pipeline
   typedef struct packed {
      logic valid;   // stage holds a transaction
      logic bypass;  // result is the base value, no quotient added
      logic neg;     // quotient is negative
   } dam_ctrl_type;

   localparam int REG_INDEX_BITS = 3;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_EDGE_LOW    = 3'd0,
      REG_EDGE_HIGH   = 3'd1,
      REG_CENTER_LOW  = 3'd2,
      REG_CENTER_HIGH = 3'd3,
      REG_OUT_LOW     = 3'd4,
      REG_OUT_MID     = 3'd5,
      REG_OUT_HIGH    = 3'd6
   } dam_reg_type;

endpackage

>>> rtl/dam_prep.sv
// dam_prep: region select, span and offset, product and magnitudes.
// Three register stages ahead of the divider chain.
// Depends on dam_pkg.
module dam_prep #(
   parameter int SAMPLE_BITS = 10,
   parameter int OUT_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [SAMPLE_BITS-1:0]               raw_sample,
   input  logic [SAMPLE_BITS-1:0]               edge_low,
   input  logic [SAMPLE_BITS-1:0]               edge_high,
   input  logic [SAMPLE_BITS-1:0]               center_low,
   input  logic [SAMPLE_BITS-1:0]               center_high,
   input  logic signed [OUT_BITS-1:0]           out_low,
   input  logic signed [OUT_BITS-1:0]           out_mid,
   input  logic signed [OUT_BITS-1:0]           out_high,
   output dam_pkg::dam_ctrl_type                ctrl_o,
   output logic [SAMPLE_BITS+OUT_BITS-1:0]      num_o,
   output logic [SAMPLE_BITS-1:0]               div_o,
   output logic signed [OUT_BITS-1:0]           base_o
);
   import dam_pkg::*;

   localparam int S = SAMPLE_BITS;
   localparam int O = OUT_BITS;
   localparam int P = SAMPLE_BITS + OUT_BITS;

   // stage A: operands
   logic                 above, below;
   logic [S-1:0]         a_lo, a_hi;
   logic signed [O-1:0]  c_val, d_val, zero_val;
   logic signed [S:0]    dx_in, span_in;
   logic signed [O:0]    dy_in;
   logic signed [O-1:0]  base_a_in;
   dam_ctrl_type         ctrl_a_in;

   logic signed [S:0]    dx_ff, span_a_ff;
   logic signed [O:0]    dy_ff;
   logic signed [O-1:0]  base_a_ff;
   dam_ctrl_type         ctrl_a_ff;

   // stage B: product
   logic signed [P+1:0]  prod_in;
   logic signed [P+1:0]  prod_ff;
   logic signed [S:0]    span_b_ff;
   logic signed [O-1:0]  base_b_ff;
   dam_ctrl_type         ctrl_b_ff;

   // stage C: magnitudes and quotient sign
   logic signed [P+1:0]  prod_abs;
   logic signed [S:0]    span_abs;
   dam_ctrl_type         ctrl_c_in;
   logic [P-1:0]         num_ff;
   logic [S-1:0]         div_ff;
   logic signed [O-1:0]  base_c_ff;
   dam_ctrl_type         ctrl_c_ff;

   always_comb begin
      above = raw_sample > center_high;
      below = raw_sample < center_low;
      // the upper region wins when the band is inverted
      if (above) begin
         a_lo     = center_high;
         a_hi     = edge_high;
         c_val    = out_mid;
         d_val    = out_high;
         zero_val = out_high;
      end else begin
         a_lo     = edge_low;
         a_hi     = center_low;
         c_val    = out_low;
         d_val    = out_mid;
         zero_val = out_low;
      end
      dx_in   = $signed({1'b0, raw_sample}) - $signed({1'b0, a_lo});
      span_in = $signed({1'b0, a_hi}) - $signed({1'b0, a_lo});
      dy_in   = $signed({d_val[O-1], d_val}) - $signed({c_val[O-1], c_val});
      if (!(above || below)) begin
         base_a_in = out_mid;
      end else if (span_in == '0) begin
         base_a_in = zero_val;
      end else begin
         base_a_in = c_val;
      end
      ctrl_a_in.valid  = in_valid;
      ctrl_a_in.bypass = !(above || below) || (span_in == '0);
      ctrl_a_in.neg    = 1'b0;
   end

   assign prod_in = dx_ff * dy_ff;

   always_comb begin
      prod_abs  = prod_ff[P+1] ? -prod_ff : prod_ff;
      span_abs  = span_b_ff[S] ? -span_b_ff : span_b_ff;
      ctrl_c_in = ctrl_b_ff;
      ctrl_c_in.neg = prod_ff[P+1] ^ span_b_ff[S];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
         ctrl_c_ff <= '0;
      end else if (advance) begin
         ctrl_a_ff <= ctrl_a_in;
         ctrl_b_ff <= ctrl_a_ff;
         ctrl_c_ff <= ctrl_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         span_a_ff <= span_in;
         base_a_ff <= base_a_in;
         prod_ff   <= prod_in;
         span_b_ff <= span_a_ff;
         base_b_ff <= base_a_ff;
         num_ff    <= prod_abs[P-1:0];
         div_ff    <= span_abs[S-1:0];
         base_c_ff <= base_b_ff;
      end
   end

   assign ctrl_o = ctrl_c_ff;
   assign num_o  = num_ff;
   assign div_o  = div_ff;
   assign base_o = base_c_ff;

endmodule

>>> rtl/dam_div_cell.sv
// dam_div_cell: one restoring-division cell, one quotient bit per cell.
// Shifts the dividend out at the top and the quotient bit in at the bottom.
// Depends on dam_pkg.
module dam_div_cell #(
   parameter int SAMPLE_BITS = 10,
   parameter int OUT_BITS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  dam_pkg::dam_ctrl_type            ctrl_i,
   input  logic [SAMPLE_BITS+OUT_BITS-1:0]  numq_i,
   input  logic [SAMPLE_BITS-1:0]           rem_i,
   input  logic [SAMPLE_BITS-1:0]           div_i,
   input  logic signed [OUT_BITS-1:0]       base_i,
   output dam_pkg::dam_ctrl_type            ctrl_o,
   output logic [SAMPLE_BITS+OUT_BITS-1:0]  numq_o,
   output logic [SAMPLE_BITS-1:0]           rem_o,
   output logic [SAMPLE_BITS-1:0]           div_o,
   output logic signed [OUT_BITS-1:0]       base_o
);
   import dam_pkg::*;

   localparam int S = SAMPLE_BITS;
   localparam int P = SAMPLE_BITS + OUT_BITS;

   logic [S:0]           trial;
   logic [S:0]           diff;
   logic                 q_bit;
   logic [S-1:0]         rem_in;
   logic [P-1:0]         numq_in;

   dam_ctrl_type         ctrl_ff;
   logic [P-1:0]         numq_ff;
   logic [S-1:0]         rem_ff;
   logic [S-1:0]         div_ff;
   logic signed [OUT_BITS-1:0] base_ff;

   always_comb begin
      trial   = {rem_i, numq_i[P-1]};
      diff    = trial - {1'b0, div_i};
      q_bit   = trial >= {1'b0, div_i};
      rem_in  = q_bit ? diff[S-1:0] : trial[S-1:0];
      numq_in = {numq_i[P-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         numq_ff <= numq_in;
         rem_ff  <= rem_in;
         div_ff  <= div_i;
         base_ff <= base_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign numq_o = numq_ff;
   assign rem_o  = rem_ff;
   assign div_o  = div_ff;
   assign base_o = base_ff;

endmodule

>>> rtl/dam_finish.sv
// dam_finish: sign the quotient, add the region offset, saturate, output register.
// Holds the result until the downstream side takes it.
// Depends on dam_pkg.
module dam_finish #(
   parameter int SAMPLE_BITS = 10,
   parameter int OUT_BITS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  dam_pkg::dam_ctrl_type            ctrl_i,
   input  logic [SAMPLE_BITS+OUT_BITS-1:0]  quot_i,
   input  logic signed [OUT_BITS-1:0]       base_i,
   output logic                             out_valid,
   output logic signed [OUT_BITS-1:0]       out_value
);
   import dam_pkg::*;

   localparam int O = OUT_BITS;
   localparam int P = SAMPLE_BITS + OUT_BITS;
   localparam logic signed [P+1:0] SAT_HI = {{(P+3-O){1'b0}}, {(O-1){1'b1}}};
   localparam logic signed [P+1:0] SAT_LO = {{(P+3-O){1'b1}}, {(O-1){1'b0}}};

   logic signed [P:0]    quot_pos;
   logic signed [P:0]    quot_s;
   logic signed [P+1:0]  sum;
   logic signed [O-1:0]  value_in;

   logic                 valid_ff;
   logic signed [O-1:0]  value_ff;

   always_comb begin
      quot_pos = $signed({1'b0, quot_i});
      quot_s   = ctrl_i.neg ? -quot_pos : quot_pos;
      sum      = {quot_s[P], quot_s} + {{(P+2-O){base_i[O-1]}}, base_i};
      if (ctrl_i.bypass) begin
         value_in = base_i;
      end else if (sum > SAT_HI) begin
         value_in = SAT_HI[O-1:0];
      end else if (sum < SAT_LO) begin
         value_in = SAT_LO[O-1:0];
      end else begin
         value_in = sum[O-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctrl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

>>> rtl/deadband_axis_mapper_core.sv
// deadband_axis_mapper_core: joystick axis calibration with a centre dead zone.
// Top level: configuration registers, prep stages, divider cell chain, finish stage.
// Depends on dam_pkg, dam_prep, dam_div_cell, dam_finish.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid req_ready req_raw_sample  | in
//   rsp     | rsp_valid rsp_ready rsp_mapped_value| out
//   csr     | csr_valid csr_ready csr_index       | in
//           | csr_wdata                           |
//
// One transaction enters per cycle while the output is not stalled. The pipeline is
// three prep stages, one divider cell per quotient bit,
// one output register. The divider cell chain sets the latency.
// Synchronous reset clears all valid flags and loads the register defaults.
// A stalled output freezes the whole pipeline, empty stages included.
module deadband_axis_mapper_core #(
   parameter int SAMPLE_BITS = 10,
   parameter int OUT_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_raw_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [OUT_BITS-1:0]            rsp_mapped_value,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dam_pkg::REG_INDEX_BITS-1:0]    csr_index,
   input  logic [((SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS)-1:0] csr_wdata
);
   import dam_pkg::*;

   localparam int S = SAMPLE_BITS;
   localparam int O = OUT_BITS;
   // quotient width, and so the number of divider cells
   localparam int P = SAMPLE_BITS + OUT_BITS;

   logic advance;

   // calibration registers
   logic [S-1:0]         edge_low_ff, edge_high_ff, center_low_ff, center_high_ff;
   logic signed [O-1:0]  out_low_ff, out_mid_ff, out_high_ff;

   // divider chain links: entry 0 feeds the first cell
   dam_ctrl_type         ctrl_w [0:P];
   logic [P-1:0]         numq_w [0:P];
   logic [S-1:0]         rem_w  [0:P];
   logic [S-1:0]         div_w  [0:P];
   logic signed [O-1:0]  base_w [0:P];

   // advance every stage unless a finished result is waiting on a stalled output
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_low_ff    <= '0;
         edge_high_ff   <= S'(1023);
         center_low_ff  <= S'(511);
         center_high_ff <= S'(512);
         out_low_ff     <= '0;
         out_mid_ff     <= O'(512);
         out_high_ff    <= O'(1023);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_EDGE_LOW:    edge_low_ff    <= csr_wdata[S-1:0];
            REG_EDGE_HIGH:   edge_high_ff   <= csr_wdata[S-1:0];
            REG_CENTER_LOW:  center_low_ff  <= csr_wdata[S-1:0];
            REG_CENTER_HIGH: center_high_ff <= csr_wdata[S-1:0];
            REG_OUT_LOW:     out_low_ff     <= csr_wdata[O-1:0];
            REG_OUT_MID:     out_mid_ff     <= csr_wdata[O-1:0];
            REG_OUT_HIGH:    out_high_ff    <= csr_wdata[O-1:0];
            default: ;
         endcase
      end
   end

   // pick the region, form the span and product, take magnitudes
   dam_prep #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .OUT_BITS    (OUT_BITS)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid && req_ready),
      .raw_sample  (req_raw_sample),
      .edge_low    (edge_low_ff),
      .edge_high   (edge_high_ff),
      .center_low  (center_low_ff),
      .center_high (center_high_ff),
      .out_low     (out_low_ff),
      .out_mid     (out_mid_ff),
      .out_high    (out_high_ff),
      .ctrl_o      (ctrl_w[0]),
      .num_o       (numq_w[0]),
      .div_o       (div_w[0]),
      .base_o      (base_w[0])
   );

   // partial remainder starts at zero
   assign rem_w[0] = '0;

   // one cell per quotient bit, most significant first
   for (genvar k = 0; k < P; k++) begin : g_cell
      dam_div_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .OUT_BITS    (OUT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctrl_i  (ctrl_w[k]),
         .numq_i  (numq_w[k]),
         .rem_i   (rem_w[k]),
         .div_i   (div_w[k]),
         .base_i  (base_w[k]),
         .ctrl_o  (ctrl_w[k+1]),
         .numq_o  (numq_w[k+1]),
         .rem_o   (rem_w[k+1]),
         .div_o   (div_w[k+1]),
         .base_o  (base_w[k+1])
      );
   end

   // after the last cell the shifted word holds the whole quotient magnitude;
   // the remainder is dropped since division truncates toward zero
   dam_finish #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .OUT_BITS    (OUT_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctrl_i    (ctrl_w[P]),
      .quot_i    (numq_w[P]),
      .base_i    (base_w[P]),
      .out_valid (rsp_valid),
      .out_value (rsp_mapped_value)
   );

   // final remainder and divisor leave the chain unused beyond the last cell
   logic unused_tail;
   assign unused_tail = ^{rem_w[P], div_w[P]};

endmodule

>>> tb/tb_axis_map_checker.sv
// axis_map_checker: watches the sample, result and register channels of the
// deadband axis mapper, predicts each calibrated value and compares in order.
// Depends on dam_pkg for the register index codes.
module axis_map_checker #(
   parameter int SAMPLE_BITS = 10,
   parameter int OUT_BITS    = 16,
   parameter int WDATA_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_raw_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [OUT_BITS-1:0]          rsp_mapped_value,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dam_pkg::REG_INDEX_BITS-1:0]  csr_index,
   input  logic [WDATA_BITS-1:0]               csr_wdata,
   output int                                  failures,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import dam_pkg::*;

   logic [SAMPLE_BITS-1:0]     edge_low, edge_high, center_low, center_high;
   logic signed [OUT_BITS-1:0] out_low, out_mid, out_high;
   logic signed [OUT_BITS-1:0] expected_values[$];
   logic signed [OUT_BITS-1:0] want;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   // straight line through (a, c) and (b, d); a flat span gives the outer value
   function automatic longint segment_value(longint x, longint a, longint b,
                                            longint c, longint d, longint flat);
      if (b == a) return flat;
      return (x - a) * (d - c) / (b - a) + c;
   endfunction

   function automatic logic signed [OUT_BITS-1:0] calibrated_value(
      logic [SAMPLE_BITS-1:0] raw);
      longint r, top_lim, bot_lim;
      top_lim = (longint'(1) <<< (OUT_BITS - 1)) - 1;
      bot_lim = -top_lim - 1;
      // above the band wins even when the band is inverted
      if (raw > center_high)
         r = segment_value(longint'(raw), center_high, edge_high, out_mid, out_high, out_high);
      else if (raw < center_low)
         r = segment_value(longint'(raw), edge_low, center_low, out_low, out_mid, out_low);
      else
         r = out_mid;
      if (r > top_lim) r = top_lim;
      else if (r < bot_lim) r = bot_lim;
      return r[OUT_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         edge_low    = '0;
         edge_high   = SAMPLE_BITS'(1023);
         center_low  = SAMPLE_BITS'(511);
         center_high = SAMPLE_BITS'(512);
         out_low     = '0;
         out_mid     = OUT_BITS'(512);
         out_high    = OUT_BITS'(1023);
         expected_values.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $error("mapped_value: expected nothing, actual %0d", rsp_mapped_value);
               failures++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_mapped_value !== want) begin
                  $error("mapped_value: expected %0d, actual %0d", want, rsp_mapped_value);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_values.push_back(calibrated_value(req_raw_sample));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_EDGE_LOW:    edge_low    = csr_wdata[SAMPLE_BITS-1:0];
               REG_EDGE_HIGH:   edge_high   = csr_wdata[SAMPLE_BITS-1:0];
               REG_CENTER_LOW:  center_low  = csr_wdata[SAMPLE_BITS-1:0];
               REG_CENTER_HIGH: center_high = csr_wdata[SAMPLE_BITS-1:0];
               REG_OUT_LOW:     out_low     = csr_wdata[OUT_BITS-1:0];
               REG_OUT_MID:     out_mid     = csr_wdata[OUT_BITS-1:0];
               REG_OUT_HIGH:    out_high    = csr_wdata[OUT_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_values.size();
   end

endmodule

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for deadband_axis_mapper_core.
// Drives samples and register writes, throttles the result side, and relies on
// axis_map_checker (tb_axis_map_checker.sv) and dam_pkg for prediction and codes.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dam_pkg::*;

   localparam int SAMPLE_BITS    = 10;
   localparam int OUT_BITS       = 16;
   localparam int WDATA_BITS     = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS;
   localparam int PIPE_LATENCY   = SAMPLE_BITS + OUT_BITS + 4;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_SAMPLES = 1500;
   localparam int IDLE_PERCENT   = 22;
   localparam int CYCLE_LIMIT    = 200000;
   // index past the end of the register list; writes to it must be dropped
   localparam logic [REG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

   logic clock;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [SAMPLE_BITS-1:0]        req_raw_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0]    rsp_mapped_value;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [REG_INDEX_BITS-1:0]     csr_index = '0;
   logic [WDATA_BITS-1:0]         csr_wdata = '0;

   int failures;
   int outstanding;
   int cycle_count = 0;
   // no idling on either side while this is set
   logic steady = 1'b0;
   // current band and edge points, indexed by register code, to aim samples at
   int knee[4] = '{0, 1023, 511, 512};

   deadband_axis_mapper_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .OUT_BITS    (OUT_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mapped_value (rsp_mapped_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   axis_map_checker #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .OUT_BITS    (OUT_BITS),
      .WDATA_BITS  (WDATA_BITS)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mapped_value (rsp_mapped_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: stall at random unless a steady stretch is running
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // watchdog: a hung pipeline or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Offer one sample transaction and hold it until accepted. Valid is left
   // high afterwards so back-to-back samples never drop it within a step.
   task automatic send_sample(input int raw);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= SAMPLE_BITS'(raw);
      do @(posedge clock); while (!req_ready);
   endtask

   // One register write transaction; the caller lowers csr_valid after a batch.
   task automatic write_reg(input logic [REG_INDEX_BITS-1:0] index,
                            input logic [WDATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index <= REG_CENTER_HIGH) knee[index] = int'(data[SAMPLE_BITS-1:0]);
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stop offering samples and wait until every result has been taken, so
   // the block is idle before its registers change.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Directed calibration: write all seven registers, optionally poke the
   // unused index afterwards.
   task automatic calibrate(input int el, input int eh, input int cl, input int ch,
                            input int ol, input int om, input int oh, input bit spare);
      settle();
      write_reg(REG_EDGE_LOW,    WDATA_BITS'(el));
      write_reg(REG_EDGE_HIGH,   WDATA_BITS'(eh));
      write_reg(REG_CENTER_LOW,  WDATA_BITS'(cl));
      write_reg(REG_CENTER_HIGH, WDATA_BITS'(ch));
      write_reg(REG_OUT_LOW,     WDATA_BITS'(ol));
      write_reg(REG_OUT_MID,     WDATA_BITS'(om));
      write_reg(REG_OUT_HIGH,    WDATA_BITS'(oh));
      if (spare) write_reg(REG_SPARE, '1);
      csr_valid <= 1'b0;
   endtask

   // Mostly an ordered edge/band layout with random points; now and then a
   // scrambled one, junk in the unused upper data bits, skipped registers,
   // or a write to the unused index.
   task automatic program_random_calibration();
      int pts[4];
      int swap, base;
      logic [WDATA_BITS-1:0] vals[7];
      for (int i = 0; i < 4; i++) pts[i] = $urandom_range(SAMPLE_MAX);
      if ($urandom_range(9) < 7) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
               if (pts[j] > pts[j+1]) begin
                  swap = pts[j];
                  pts[j] = pts[j+1];
                  pts[j+1] = swap;
               end
         if ($urandom_range(3) == 0) begin
            pts[0] = 0;
            pts[3] = SAMPLE_MAX;
         end
      end
      vals[REG_EDGE_LOW]    = WDATA_BITS'(pts[0]);
      vals[REG_CENTER_LOW]  = WDATA_BITS'(pts[1]);
      vals[REG_CENTER_HIGH] = WDATA_BITS'(pts[2]);
      vals[REG_EDGE_HIGH]   = WDATA_BITS'(pts[3]);
      for (int r = 0; r <= REG_CENTER_HIGH; r++)
         if ($urandom_range(7) == 0)
            vals[r][WDATA_BITS-1:SAMPLE_BITS] = (WDATA_BITS-SAMPLE_BITS)'($urandom);
      if ($urandom_range(1) == 0) begin
         vals[REG_OUT_LOW]  = WDATA_BITS'($urandom);
         vals[REG_OUT_MID]  = WDATA_BITS'($urandom);
         vals[REG_OUT_HIGH] = WDATA_BITS'($urandom);
      end else begin
         // a gentle, mostly monotonic curve around a small mid value
         base = int'($urandom_range(2000)) - 1000;
         vals[REG_OUT_MID]  = WDATA_BITS'(base);
         vals[REG_OUT_LOW]  = WDATA_BITS'(base - int'($urandom_range(4000)));
         vals[REG_OUT_HIGH] = WDATA_BITS'(base + int'($urandom_range(4000)));
      end
      for (int r = 0; r <= REG_OUT_HIGH; r++)
         if ($urandom_range(7) != 0) write_reg(r[REG_INDEX_BITS-1:0], vals[r]);
      if ($urandom_range(5) == 0) write_reg(REG_SPARE, WDATA_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Bias towards the rail codes and the neighbourhood of each knee point.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = SAMPLE_MAX;
         2, 3, 4: v = knee[$urandom_range(3)] + int'($urandom_range(6)) - 3;
         default: v = $urandom_range(SAMPLE_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v[SAMPLE_BITS-1:0];
   endfunction

   initial begin
      int sent, pass_no, burst;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: rails and both sides of the two-code centre band
      settle();
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(511);
      send_sample(512);
      send_sample(510);
      send_sample(513);

      // flat lower span drops to out_low; top rail extrapolates past +full scale
      calibrate(300, 1000, 300, 700, -32768, 0, 32767, 1'b0);
      send_sample(0);
      send_sample(299);
      send_sample(300);
      send_sample(SAMPLE_MAX);

      // flat upper span jumps to out_high; falling lower segment
      calibrate(100, 600, 400, 600, 100, -100, -32768, 1'b0);
      send_sample(601);
      send_sample(SAMPLE_MAX);
      send_sample(50);

      // inverted band: above the upper point takes the upper segment first
      calibrate(0, 1023, 700, 300, -1000, 0, 1000, 1'b0);
      send_sample(400);
      send_sample(200);
      send_sample(SAMPLE_MAX);

      // inverted edges: negative spans on both segments
      calibrate(1023, 0, 400, 600, -5000, 5, 5000, 1'b0);
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(500);

      // one-code spans with full-scale swings: both rails saturate negative
      calibrate(500, 503, 501, 502, -32768, 32767, -32768, 1'b0);
      send_sample(0);
      send_sample(SAMPLE_MAX);

      // edge and band points at their maximum, outputs at the extremes, plus a write to the unused index
      calibrate(1023, 1023, 1023, 1023, 32767, -32768, 32767, 1'b1);
      send_sample(SAMPLE_MAX);
      send_sample(0);

      // everything at zero
      calibrate(0, 0, 0, 0, 0, 0, 0, 1'b0);
      send_sample(0);
      send_sample(1);

      // random phases: recalibrate while idle, then a burst of samples
      sent    = 0;
      pass_no = 0;
      while (sent < RANDOM_SAMPLES) begin
         settle();
         // one long phase runs with no idling on either side
         steady <= (pass_no == 3);
         if (pass_no == 0 || $urandom_range(4) != 0) program_random_calibration();
         burst = (pass_no == 3) ? 300 : $urandom_range(30, 150);
         repeat (burst) send_sample(pick_sample());
         sent += burst;
         pass_no++;
      end

      settle();
      repeat (PIPE_LATENCY) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

>>> files.f
rtl/dam_pkg.sv
rtl/dam_prep.sv
rtl/dam_div_cell.sv
rtl/dam_finish.sv
rtl/deadband_axis_mapper_core.sv
tb/tb_axis_map_checker.sv
tb/tb_top.sv
